### hw/rtl/rfmsd_pkg.sv
package rfmsd_pkg;

   // drive scaling
   localparam int unsigned FULL_SCALE      = 1000;
   localparam int unsigned SPEED_SPAN      = 95;
   localparam int unsigned RAMP_LIMIT      = 8191;
   localparam int unsigned DUTY_MAX        = 1023;
   localparam int unsigned SPEED_LUT_DEPTH = 128;
   localparam int unsigned JOINT_COUNT     = 6;

   // frame byte codes
   localparam logic [7:0] FRAME_END_CODE  = 8'd34;
   localparam logic [7:0] CODE_FORWARD    = 8'd48;
   localparam logic [7:0] CODE_RIGHT_REV  = 8'd49;
   localparam logic [7:0] CODE_LEFT_REV   = 8'd50;
   localparam logic [7:0] SPEED_LOW       = 8'd32;
   localparam logic [7:0] SPEED_HIGH      = 8'd127;

   localparam logic [7:0] JOINT_LEFT_CODE  [JOINT_COUNT] = '{8'd51, 8'd53, 8'd55,
                                                             8'd57, 8'd59, 8'd62};
   localparam logic [7:0] JOINT_RIGHT_CODE [JOINT_COUNT] = '{8'd52, 8'd54, 8'd56,
                                                             8'd58, 8'd60, 8'd63};
   localparam logic [7:0] JOINT_STOP_CODE  [JOINT_COUNT] = '{8'd48, 8'd48, 8'd48,
                                                             8'd48, 8'd61, 8'd64};

   // configuration defaults
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [11:0] STEP_RESET    = 12'd1;
   localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_TICK  = 2'd1,
      OP_CTRL  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_TIMEOUT    = 2'd0,
      CSR_RAMP_STEP  = 2'd1,
      CSR_JOINT_DUTY = 2'd2,
      CSR_SPARE      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DRIVE_OFF = 2'd0,
      DRIVE_FWD = 2'd1,
      DRIVE_REV = 2'd2
   } drive_dir_type;

   typedef enum logic [1:0] {
      JOINT_STOP  = 2'd0,
      JOINT_LEFT  = 2'd1,
      JOINT_RIGHT = 2'd2
   } joint_cmd_type;

   typedef logic signed [13:0] ramp_type;
   typedef logic [11:0]        step_type;
   typedef logic [12:0]        speed_lut_type [SPEED_LUT_DEPTH];

   typedef struct packed {
      logic [9:0]    duty;
      drive_dir_type dir;
   } drive_type;

   typedef struct packed {
      drive_type                         right;
      drive_type                         left;
      joint_cmd_type [JOINT_COUNT-1:0]   joint_cmd;
      logic                              radio_restart;
   } rsp_type;

   // quarter-unit drive magnitude for speed character minus 32
   function automatic speed_lut_type build_speed_lut();
      speed_lut_type lut;
      int unsigned   m;
      for (int i = 0; i < SPEED_LUT_DEPTH; i++) begin
         m = (i * FULL_SCALE) / SPEED_SPAN;
         m = (m & 32'hFFFF) * 4;
         if (m > RAMP_LIMIT) m = RAMP_LIMIT;
         lut[i] = m[12:0];
      end
      return lut;
   endfunction

   localparam speed_lut_type SPEED_LUT = build_speed_lut();

   function automatic joint_cmd_type joint_decode(logic [7:0] code, logic [7:0] left,
                                                  logic [7:0] right);
      joint_cmd_type cmd;
      cmd = JOINT_STOP;
      if (code == left) cmd = JOINT_LEFT;
      else if (code == right) cmd = JOINT_RIGHT;
      return cmd;
   endfunction

   // move ramp toward target by at most step, never past it
   function automatic ramp_type slew(ramp_type ramp, ramp_type target, step_type step);
      logic signed [14:0] diff;
      logic signed [14:0] step_s;
      logic signed [14:0] moved;
      diff   = 15'(target) - 15'(ramp);
      step_s = $signed({3'b000, step});
      moved  = 15'(ramp);
      if (diff > 0) begin
         if (diff < step_s) moved = 15'(target);
         else moved = 15'(ramp) + step_s;
      end else if (diff < 0) begin
         if (-diff < step_s) moved = 15'(target);
         else moved = 15'(ramp) - step_s;
      end
      return moved[13:0];
   endfunction

   // zero ramp keeps the previous duty and pins
   function automatic drive_type drive_out(ramp_type ramp, drive_type held);
      drive_type  res;
      logic [13:0] mag;
      logic [11:0] quarters;
      res = held;
      mag = ramp[13] ? 14'(-ramp) : 14'(ramp);
      quarters = mag[13:2];
      if (ramp != '0) begin
         res.dir  = ramp[13] ? DRIVE_REV : DRIVE_FWD;
         res.duty = (quarters > 12'(DUTY_MAX)) ? 10'(DUTY_MAX) : quarters[9:0];
      end
      return res;
   endfunction

endpackage

### hw/rtl/radio_frame_motor_slew_drive.sv
// channel | ports                       | accepted when
// --------+-----------------------------+----------------------------------
// req     | req_valid, req_stall, req_* | req_valid high, req_stall low
// rsp     | rsp_valid, rsp_stall, rsp_* | rsp_valid high, rsp_stall low
// csr     | csr_we, csr_index, csr_wdata| csr_we high
//
// One item per cycle while req_stall is low: the silence counter, drive ramps and joint
// commands update in the cycle an item is taken; a control pass result is registered
// into the output register, or into the skid when the output register is full.
// A two-entry output (register plus skid) takes the stall; req_stall rises
// only while both entries hold results.
// Synchronous active-high reset restores the register defaults and zeroes
// all ramps, held commands, the frame flag and the silence count.
module radio_frame_motor_slew_drive (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_right_dir_code,
   input  logic [7:0] req_left_dir_code,
   input  logic [7:0] req_joint0_code,
   input  logic [7:0] req_joint1_code,
   input  logic [7:0] req_joint2_code,
   input  logic [7:0] req_joint3_code,
   input  logic [7:0] req_right_speed,
   input  logic [7:0] req_left_speed,
   input  logic [7:0] req_joint4_code,
   input  logic [7:0] req_joint5_code,
   input  logic [7:0] req_frame_end,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_right_duty,
   output logic [1:0] rsp_right_dir,
   output logic [9:0] rsp_left_duty,
   output logic [1:0] rsp_left_dir,
   output logic [1:0] rsp_joint0_cmd,
   output logic [1:0] rsp_joint1_cmd,
   output logic [1:0] rsp_joint2_cmd,
   output logic [1:0] rsp_joint3_cmd,
   output logic [1:0] rsp_joint4_cmd,
   output logic [1:0] rsp_joint5_cmd,
   output logic       rsp_radio_restart,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rfmsd_pkg::*;

   // configuration; writes to the joint duty index are ignored and store nothing
   logic [15:0] timeout_ff;
   step_type    step_ff;

   logic [15:0]   silence_ff, silence_in;
   logic          frame_valid_ff, frame_valid_in;
   ramp_type      right_target_ff, right_target_in;
   ramp_type      left_target_ff, left_target_in;
   joint_cmd_type frame_joint_ff [JOINT_COUNT];
   joint_cmd_type frame_joint_in [JOINT_COUNT];

   ramp_type      right_ramp_ff, right_ramp_in;
   ramp_type      left_ramp_ff, left_ramp_in;
   drive_type     right_drive_ff, right_drive_in;
   drive_type     left_drive_ff, left_drive_in;
   joint_cmd_type held_joint_ff [JOINT_COUNT];
   joint_cmd_type held_joint_in [JOINT_COUNT];

   rsp_type rsp_ff, rsp_in;
   rsp_type skid_ff, skid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic       req_take;
   logic       rsp_take;
   logic       new_rsp;
   logic       timed_out;
   logic       ramp_go;
   logic [7:0] joint_code [JOINT_COUNT];
   logic       joints_ok;
   logic       frame_ok;
   logic [6:0] right_idx, left_idx;
   rsp_type    res;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign timed_out = silence_ff > timeout_ff;
   assign ramp_go   = timed_out || frame_valid_ff;

   always_comb begin
      joint_code[0] = req_joint0_code;
      joint_code[1] = req_joint1_code;
      joint_code[2] = req_joint2_code;
      joint_code[3] = req_joint3_code;
      joint_code[4] = req_joint4_code;
      joint_code[5] = req_joint5_code;

      joints_ok = 1'b1;
      for (int j = 0; j < JOINT_COUNT; j++) begin
         frame_joint_in[j] = frame_joint_ff[j];
         held_joint_in[j]  = held_joint_ff[j];
         if (!(joint_code[j] == JOINT_STOP_CODE[j] || joint_code[j] == JOINT_LEFT_CODE[j]
               || joint_code[j] == JOINT_RIGHT_CODE[j]))
            joints_ok = 1'b0;
      end

      frame_ok = (req_frame_end == FRAME_END_CODE)
         && (req_right_dir_code == CODE_FORWARD || req_right_dir_code == CODE_RIGHT_REV)
         && (req_left_dir_code == CODE_FORWARD || req_left_dir_code == CODE_LEFT_REV)
         && joints_ok
         && req_right_speed >= SPEED_LOW && req_right_speed <= SPEED_HIGH
         && req_left_speed >= SPEED_LOW && req_left_speed <= SPEED_HIGH;

      right_idx = 7'(req_right_speed - SPEED_LOW);
      left_idx  = 7'(req_left_speed - SPEED_LOW);

      silence_in      = silence_ff;
      frame_valid_in  = frame_valid_ff;
      right_target_in = right_target_ff;
      left_target_in  = left_target_ff;
      right_ramp_in   = right_ramp_ff;
      left_ramp_in    = left_ramp_ff;
      right_drive_in  = right_drive_ff;
      left_drive_in   = left_drive_ff;
      new_rsp         = 1'b0;

      if (req_take) begin
         unique case (opcode_type'(req_opcode))
            OP_FRAME: begin
               // decode the frame now; only decoded targets and commands are kept
               silence_in      = '0;
               frame_valid_in  = frame_ok;
               right_target_in = 14'(SPEED_LUT[right_idx]);
               left_target_in  = 14'(SPEED_LUT[left_idx]);
               if (req_right_dir_code == CODE_RIGHT_REV) right_target_in = -right_target_in;
               if (req_left_dir_code == CODE_LEFT_REV) left_target_in = -left_target_in;
               for (int j = 0; j < JOINT_COUNT; j++)
                  frame_joint_in[j] = joint_decode(joint_code[j], JOINT_LEFT_CODE[j],
                                                   JOINT_RIGHT_CODE[j]);
            end
            OP_TICK: begin
               if (silence_ff != SILENCE_MAX) silence_in = silence_ff + 16'd1;
            end
            OP_CTRL: begin
               new_rsp = 1'b1;
               if (ramp_go) begin
                  right_ramp_in  = slew(right_ramp_ff, timed_out ? '0 : right_target_ff,
                                        step_ff);
                  left_ramp_in   = slew(left_ramp_ff, timed_out ? '0 : left_target_ff,
                                        step_ff);
                  right_drive_in = drive_out(right_ramp_in, right_drive_ff);
                  left_drive_in  = drive_out(left_ramp_in, left_drive_ff);
                  for (int j = 0; j < JOINT_COUNT; j++)
                     held_joint_in[j] = timed_out ? JOINT_STOP : frame_joint_ff[j];
               end
            end
            default: ;
         endcase
      end

      res.right         = right_drive_in;
      res.left          = left_drive_in;
      res.radio_restart = timed_out;
      for (int j = 0; j < JOINT_COUNT; j++) res.joint_cmd[j] = held_joint_in[j];

      // output register plus skid: fill in order, drain the skid first
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res;
            rsp_valid_in = new_rsp;
         end
      end else if (new_rsp) begin
         if (!rsp_valid_ff) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         step_ff         <= STEP_RESET;
         silence_ff      <= '0;
         frame_valid_ff  <= 1'b0;
         right_target_ff <= '0;
         left_target_ff  <= '0;
         right_ramp_ff   <= '0;
         left_ramp_ff    <= '0;
         right_drive_ff  <= '{duty: '0, dir: DRIVE_OFF};
         left_drive_ff   <= '{duty: '0, dir: DRIVE_OFF};
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
         for (int j = 0; j < JOINT_COUNT; j++) begin
            frame_joint_ff[j] <= JOINT_STOP;
            held_joint_ff[j]  <= JOINT_STOP;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_TIMEOUT:   timeout_ff <= csr_wdata;
               CSR_RAMP_STEP: step_ff    <= csr_wdata[11:0];
               default: ;
            endcase
         end
         silence_ff      <= silence_in;
         frame_valid_ff  <= frame_valid_in;
         right_target_ff <= right_target_in;
         left_target_ff  <= left_target_in;
         right_ramp_ff   <= right_ramp_in;
         left_ramp_ff    <= left_ramp_in;
         right_drive_ff  <= right_drive_in;
         left_drive_ff   <= left_drive_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
         for (int j = 0; j < JOINT_COUNT; j++) begin
            frame_joint_ff[j] <= frame_joint_in[j];
            held_joint_ff[j]  <= held_joint_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_duty    = rsp_ff.right.duty;
   assign rsp_right_dir     = rsp_ff.right.dir;
   assign rsp_left_duty     = rsp_ff.left.duty;
   assign rsp_left_dir      = rsp_ff.left.dir;
   assign rsp_joint0_cmd    = rsp_ff.joint_cmd[0];
   assign rsp_joint1_cmd    = rsp_ff.joint_cmd[1];
   assign rsp_joint2_cmd    = rsp_ff.joint_cmd[2];
   assign rsp_joint3_cmd    = rsp_ff.joint_cmd[3];
   assign rsp_joint4_cmd    = rsp_ff.joint_cmd[4];
   assign rsp_joint5_cmd    = rsp_ff.joint_cmd[5];
   assign rsp_radio_restart = rsp_ff.radio_restart;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without output entry");

   a_ctrl_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_opcode == OP_CTRL) |=> rsp_valid_ff)
      else $error("control pass left no result");

   a_ramp_in_range: assert property (@(posedge clock) disable iff (reset)
      right_ramp_ff != 14'h2000 && left_ramp_ff != 14'h2000)
      else $error("drive ramp beyond limit");

   a_restart_stops_joints: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.radio_restart) |-> (rsp_ff.joint_cmd == '0))
      else $error("restart result with a moving joint");

   a_off_means_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.right.dir == DRIVE_OFF) |-> (rsp_ff.right.duty == '0))
      else $error("right drive off with nonzero duty");

endmodule
